FILE: hdl/status_led_pattern_sequencer_top_assert.svh
// assertion macros used by the sequencer top
`ifndef STATUS_LED_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define STATUS_LED_PATTERN_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define SLPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// next-cycle implication, disabled in reset
`define SLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`else

`define SLPS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/slps_pkg.sv
`timescale 1ns / 1ps

package slps_pkg;

    typedef enum logic [3:0] {
        PAT_NONE    = 4'd0,
        PAT_SETUP   = 4'd1,
        PAT_SUCCESS = 4'd2,
        PAT_ERROR   = 4'd3,
        PAT_WIFI    = 4'd4,
        PAT_IO      = 4'd5,
        PAT_RESET   = 4'd6,
        PAT_ACTIVE  = 4'd7,
        PAT_IDLE    = 4'd8
    } t_pattern;

    typedef enum logic [3:0] {
        CFG_QUICK_INTERVAL  = 4'd0,
        CFG_NORMAL_INTERVAL = 4'd1,
        CFG_SLOW_INTERVAL   = 4'd2,
        CFG_ERROR_INTERVAL  = 4'd3,
        CFG_SETUP_BLINKS    = 4'd4,
        CFG_SUCCESS_BLINKS  = 4'd5,
        CFG_ERROR_BLINKS    = 4'd6,
        CFG_WIFI_BLINKS     = 4'd7
    } t_cfg_index;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [15:0] RST_QUICK_INTERVAL  = 16'd100;
    localparam logic [15:0] RST_NORMAL_INTERVAL = 16'd500;
    localparam logic [15:0] RST_SLOW_INTERVAL   = 16'd1000;
    localparam logic [15:0] RST_ERROR_INTERVAL  = 16'd200;
    localparam logic [7:0]  RST_SETUP_BLINKS    = 8'd3;
    localparam logic [7:0]  RST_SUCCESS_BLINKS  = 8'd2;
    localparam logic [7:0]  RST_ERROR_BLINKS    = 8'd5;
    localparam logic [7:0]  RST_WIFI_BLINKS     = 8'd1;

    localparam logic [7:0]  IO_BLINKS      = 8'd2;
    localparam logic [31:0] BREATH_PERIOD  = 32'd30;
    localparam logic [7:0]  BREATH_STEP    = 8'd5;
    localparam logic [7:0]  BREATH_UP_MAX  = 8'd250;
    localparam logic [7:0]  BRIGHT_MAX     = 8'd255;

    typedef struct packed {
        logic [15:0] quick_interval;
        logic [15:0] normal_interval;
        logic [15:0] slow_interval;
        logic [15:0] error_interval;
        logic [7:0]  setup_blinks;
        logic [7:0]  success_blinks;
        logic [7:0]  error_blinks;
        logic [7:0]  wifi_blinks;
    } t_cfg;

    typedef struct packed {
        logic     pin_level;
        logic [7:0] pwm_level;
        logic     pwm_select;
        logic     pattern_active;
        t_pattern current_mode;
    } t_result;

endpackage

FILE: hdl/slps_cfg_regs.sv
`timescale 1ns / 1ps

module slps_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [slps_pkg::CFG_INDEX_W-1:0]   i_wr_index,
    input  logic [slps_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output slps_pkg::t_cfg                     o_cfg
);
    import slps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (t_cfg_index'(i_wr_index))
                CFG_QUICK_INTERVAL:  n_cfg.quick_interval  = i_wr_data;
                CFG_NORMAL_INTERVAL: n_cfg.normal_interval = i_wr_data;
                CFG_SLOW_INTERVAL:   n_cfg.slow_interval   = i_wr_data;
                CFG_ERROR_INTERVAL:  n_cfg.error_interval  = i_wr_data;
                CFG_SETUP_BLINKS:    n_cfg.setup_blinks    = i_wr_data[7:0];
                CFG_SUCCESS_BLINKS:  n_cfg.success_blinks  = i_wr_data[7:0];
                CFG_ERROR_BLINKS:    n_cfg.error_blinks    = i_wr_data[7:0];
                CFG_WIFI_BLINKS:     n_cfg.wifi_blinks     = i_wr_data[7:0];
                default:             n_cfg = r_cfg; // indexes past the list are dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quick_interval  <= RST_QUICK_INTERVAL;
            r_cfg.normal_interval <= RST_NORMAL_INTERVAL;
            r_cfg.slow_interval   <= RST_SLOW_INTERVAL;
            r_cfg.error_interval  <= RST_ERROR_INTERVAL;
            r_cfg.setup_blinks    <= RST_SETUP_BLINKS;
            r_cfg.success_blinks  <= RST_SUCCESS_BLINKS;
            r_cfg.error_blinks    <= RST_ERROR_BLINKS;
            r_cfg.wifi_blinks     <= RST_WIFI_BLINKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/slps_engine.sv
`timescale 1ns / 1ps

module slps_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_action,
    input  logic [3:0]        i_pattern,
    input  slps_pkg::t_cfg    i_cfg,
    output slps_pkg::t_result o_result
);
    import slps_pkg::*;

    logic [31:0] r_now_ms, n_now_ms;
    logic [31:0] r_last_update_ms, n_last_update_ms;
    logic [31:0] r_last_breath_ms, n_last_breath_ms;
    logic [15:0] r_active_interval, n_active_interval;
    logic        r_blink_phase, n_blink_phase;
    logic [8:0]  r_blink_count, n_blink_count;
    logic        r_running, n_running;
    t_pattern    r_pattern, n_pattern;
    logic [7:0]  r_brightness, n_brightness;
    logic        r_fade_down, n_fade_down;
    logic        r_pin_out, n_pin_out;
    logic        r_pwm_mode, n_pwm_mode;

    // per-pattern burst settings
    logic        w_toggle;
    logic        w_single;
    logic [15:0] w_interval;
    logic [7:0]  w_blinks;
    logic [8:0]  w_count_inc;
    logic        w_burst_done;
    logic [31:0] w_tick_ms;
    logic        w_due;
    logic        w_breath_due;
    logic [7:0]  w_bright_next;

    always_comb begin
        w_toggle   = 1'b0;
        w_single   = 1'b0;
        w_interval = i_cfg.normal_interval;
        w_blinks   = IO_BLINKS;
        case (r_pattern)
            PAT_SETUP: begin
                w_toggle = 1'b1; w_interval = i_cfg.quick_interval;
                w_blinks = i_cfg.setup_blinks;
            end
            PAT_SUCCESS: begin
                w_toggle = 1'b1; w_single = 1'b1;
                w_interval = i_cfg.normal_interval; w_blinks = i_cfg.success_blinks;
            end
            PAT_ERROR: begin
                w_toggle = 1'b1; w_single = 1'b1;
                w_interval = i_cfg.error_interval; w_blinks = i_cfg.error_blinks;
            end
            PAT_WIFI: begin
                w_toggle = 1'b1; w_interval = i_cfg.slow_interval;
                w_blinks = i_cfg.wifi_blinks;
            end
            PAT_IO: begin
                w_toggle = 1'b1; w_interval = i_cfg.normal_interval;
                w_blinks = IO_BLINKS;
            end
            PAT_RESET: begin
                w_toggle = 1'b1; w_single = 1'b1;
                w_interval = i_cfg.quick_interval; w_blinks = i_cfg.error_blinks;
            end
            default: begin
                w_toggle = 1'b0;
            end
        endcase
    end

    assign w_count_inc  = r_blink_count + 9'd1;
    assign w_burst_done = (w_count_inc >= {w_blinks, 1'b0});
    assign w_tick_ms    = r_now_ms + 32'd1;
    assign w_due        = r_running &&
                          ((w_tick_ms - r_last_update_ms) >= {16'd0, r_active_interval});
    assign w_breath_due = ((w_tick_ms - r_last_breath_ms) >= BREATH_PERIOD);

    always_comb begin
        if (r_fade_down) begin
            w_bright_next = (r_brightness >= BREATH_STEP) ? r_brightness - BREATH_STEP : 8'd0;
        end else begin
            w_bright_next = (r_brightness <= BREATH_UP_MAX) ? r_brightness + BREATH_STEP
                                                            : BRIGHT_MAX;
        end
    end

    always_comb begin
        n_now_ms          = r_now_ms;
        n_last_update_ms  = r_last_update_ms;
        n_last_breath_ms  = r_last_breath_ms;
        n_active_interval = r_active_interval;
        n_blink_phase     = r_blink_phase;
        n_blink_count     = r_blink_count;
        n_running         = r_running;
        n_pattern         = r_pattern;
        n_brightness      = r_brightness;
        n_fade_down       = r_fade_down;
        n_pin_out         = r_pin_out;
        n_pwm_mode        = r_pwm_mode;
        if (i_step) begin
            if (i_action) begin
                // start command
                n_blink_count = 9'd0;
                n_blink_phase = 1'b0;
                n_running     = 1'b1;
                n_pattern     = t_pattern'(i_pattern);
                n_pin_out     = 1'b1;
                n_pwm_mode    = 1'b0;
            end else begin
                n_now_ms = w_tick_ms;
                if (w_due) begin
                    n_last_update_ms = w_tick_ms;
                    if (w_toggle) begin
                        n_active_interval = w_interval;
                        n_pin_out         = ~r_blink_phase;
                        n_pwm_mode        = 1'b0;
                        n_blink_phase     = ~r_blink_phase;
                        n_blink_count     = w_burst_done ? 9'd0 : w_count_inc;
                        if (w_burst_done && w_single) begin
                            n_running = 1'b0;
                            n_pattern = PAT_IDLE;
                        end
                    end else if (r_pattern == PAT_ACTIVE) begin
                        n_pin_out  = 1'b0;
                        n_pwm_mode = 1'b0;
                    end else if (r_pattern == PAT_IDLE && w_breath_due) begin
                        n_last_breath_ms = w_tick_ms;
                        n_brightness     = w_bright_next;
                        if (w_bright_next == 8'd0 || w_bright_next == BRIGHT_MAX) begin
                            n_fade_down = ~r_fade_down;
                        end
                        n_pwm_mode = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_ms          <= 32'd0;
            r_last_update_ms  <= 32'd0;
            r_last_breath_ms  <= 32'd0;
            r_active_interval <= RST_NORMAL_INTERVAL;
            r_blink_phase     <= 1'b0;
            r_blink_count     <= 9'd0;
            r_running         <= 1'b0;
            r_pattern         <= PAT_NONE;
            r_brightness      <= 8'd0;
            r_fade_down       <= 1'b0;
            r_pin_out         <= 1'b0;
            r_pwm_mode        <= 1'b0;
        end else begin
            r_now_ms          <= n_now_ms;
            r_last_update_ms  <= n_last_update_ms;
            r_last_breath_ms  <= n_last_breath_ms;
            r_active_interval <= n_active_interval;
            r_blink_phase     <= n_blink_phase;
            r_blink_count     <= n_blink_count;
            r_running         <= n_running;
            r_pattern         <= n_pattern;
            r_brightness      <= n_brightness;
            r_fade_down       <= n_fade_down;
            r_pin_out         <= n_pin_out;
            r_pwm_mode        <= n_pwm_mode;
        end
    end

    assign o_result.pin_level      = r_pin_out;
    assign o_result.pwm_level      = BRIGHT_MAX - r_brightness;
    assign o_result.pwm_select     = r_pwm_mode;
    assign o_result.pattern_active = r_running;
    assign o_result.current_mode   = r_pattern;

endmodule

FILE: hdl/status_led_pattern_sequencer_top.sv
`timescale 1ns / 1ps

// Status LED pattern sequencer. Each input word is either a one millisecond
// tick (action 0) or a command that starts a pattern (action 1), and every word
// gives exactly one result word with the pin level, the pwm level and select,
// the running flag and the selected pattern. One word is taken per clock cycle
// when the output side keeps up; a word passes through the input register and
// then the state registers that also serve as the result register. The per-word
// step is combinational, bounded by the 32-bit elapsed-time subtract and compare.
// Registers are written on the cfg channel, which is always ready; the user must
// write them only while no word is in flight, the block itself does not enforce it.
module status_led_pattern_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_action,
    input  logic [3:0]                       i_pattern,
    // result words
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_pin_level,
    output logic [7:0]                       o_pwm_level,
    output logic                             o_pwm_select,
    output logic                             o_pattern_active,
    output logic [3:0]                       o_current_mode,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [slps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import slps_pkg::*;

    `include "status_led_pattern_sequencer_top_assert.svh"

    // input register
    logic       r_in_valid;
    logic       r_in_action;
    logic [3:0] r_in_pattern;
    // result valid; the payload lives in the engine state
    logic       r_out_valid;

    logic       w_adv;     // the result register can take a new word
    logic       w_in_fire;
    logic       w_step;
    t_cfg       w_cfg;
    t_result    w_res;

    assign w_adv     = !r_out_valid || i_ready;
    assign w_step    = r_in_valid && w_adv;
    assign o_ready   = !r_in_valid || w_adv;
    assign w_in_fire = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_action  <= i_action;
            r_in_pattern <= i_pattern;
        end
    end

    assign o_cfg_ready = 1'b1;

    slps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // state advances only when the word moves into the result slot
    slps_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_action  (r_in_action),
        .i_pattern (r_in_pattern),
        .i_cfg     (w_cfg),
        .o_result  (w_res)
    );

    assign o_valid          = r_out_valid;
    assign o_pin_level      = w_res.pin_level;
    assign o_pwm_level      = w_res.pwm_level;
    assign o_pwm_select     = w_res.pwm_select;
    assign o_pattern_active = w_res.pattern_active;
    assign o_current_mode   = w_res.current_mode;

    // pwm drive only comes from breathing, which needs a running idle pattern
    `SLPS_ASSERT_NOW(a_pwm_only_idle, i_clk, i_rst_n, o_pwm_select, o_pattern_active && (o_current_mode == PAT_IDLE))
    // stopped means never started or a single burst ended into idle
    `SLPS_ASSERT_NOW(a_stopped_mode, i_clk, i_rst_n, !o_pattern_active, (o_current_mode == PAT_NONE) || (o_current_mode == PAT_IDLE))
    // a stepped word always shows up as a result next cycle
    `SLPS_ASSERT_NEXT(a_step_to_out, i_clk, i_rst_n, w_step, r_out_valid)
    // a held input word is not lost while the result side stalls
    `SLPS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_pattern))

endmodule

FILE: dv/slps_result_check.sv
`timescale 1ns / 1ps

module slps_result_check
    import slps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_in_action,
    input  logic [3:0]            i_in_pattern,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_pin_level,
    input  logic [7:0]            i_pwm_level,
    input  logic                  i_pwm_select,
    input  logic                  i_pattern_active,
    input  logic [3:0]            i_current_mode,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned           o_fail_count,
    output int unsigned           o_words_due
);

    localparam logic [31:0] FADE_PERIOD_MS = 32'd30;
    localparam logic [7:0]  FADE_STEP      = 8'd5;
    localparam logic [7:0]  FADE_UP_LIMIT  = 8'd250;
    localparam logic [7:0]  LEVEL_MAX      = 8'd255;
    localparam logic [7:0]  IO_BURST       = 8'd2;

    t_cfg        regs;
    logic [31:0] ms_now;
    logic [31:0] ms_last_step;
    logic [31:0] ms_last_fade;
    logic [15:0] step_period;
    logic        phase;
    logic [8:0]  toggles;
    logic        running;
    logic [3:0]  sel_pattern;
    logic [7:0]  glow;
    logic        dimming;
    logic        pin;
    logic        pwm_on;
    t_result     words_due[$];
    int unsigned mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void load_reset_state();
        regs.quick_interval  = RST_QUICK_INTERVAL;
        regs.normal_interval = RST_NORMAL_INTERVAL;
        regs.slow_interval   = RST_SLOW_INTERVAL;
        regs.error_interval  = RST_ERROR_INTERVAL;
        regs.setup_blinks    = RST_SETUP_BLINKS;
        regs.success_blinks  = RST_SUCCESS_BLINKS;
        regs.error_blinks    = RST_ERROR_BLINKS;
        regs.wifi_blinks     = RST_WIFI_BLINKS;
        ms_now       = '0;
        ms_last_step = '0;
        ms_last_fade = '0;
        step_period  = RST_NORMAL_INTERVAL;
        phase        = 1'b0;
        toggles      = '0;
        running      = 1'b0;
        sel_pattern  = PAT_NONE;
        glow         = '0;
        dimming      = 1'b0;
        pin          = 1'b0;
        pwm_on       = 1'b0;
    endfunction

    function automatic void store_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_QUICK_INTERVAL:  regs.quick_interval  = data;
            CFG_NORMAL_INTERVAL: regs.normal_interval = data;
            CFG_SLOW_INTERVAL:   regs.slow_interval   = data;
            CFG_ERROR_INTERVAL:  regs.error_interval  = data;
            CFG_SETUP_BLINKS:    regs.setup_blinks    = data[7:0];
            CFG_SUCCESS_BLINKS:  regs.success_blinks  = data[7:0];
            CFG_ERROR_BLINKS:    regs.error_blinks    = data[7:0];
            CFG_WIFI_BLINKS:     regs.wifi_blinks     = data[7:0];
            default: ;
        endcase
    endfunction

    // one pin toggle, true when the burst is complete
    function automatic logic burst_toggle(input logic [7:0] blinks);
        pin     = ~phase;
        pwm_on  = 1'b0;
        phase   = ~phase;
        toggles = toggles + 9'd1;
        if (toggles >= {blinks, 1'b0}) begin
            toggles = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void looping_burst(input logic [15:0] period, input logic [7:0] blinks);
        step_period = period;
        void'(burst_toggle(blinks));
    endfunction

    function automatic void one_shot_burst(input logic [15:0] period, input logic [7:0] blinks);
        step_period = period;
        if (burst_toggle(blinks)) begin
            running     = 1'b0;
            sel_pattern = PAT_IDLE;
        end
    endfunction

    function automatic void fade_step();
        if (ms_now - ms_last_fade >= FADE_PERIOD_MS) begin
            ms_last_fade = ms_now;
            if (dimming)
                glow = (glow >= FADE_STEP) ? glow - FADE_STEP : 8'd0;
            else
                glow = (glow <= FADE_UP_LIMIT) ? glow + FADE_STEP : LEVEL_MAX;
            if (glow == 8'd0 || glow == LEVEL_MAX)
                dimming = ~dimming;
            pwm_on = 1'b1;
        end
    endfunction

    function automatic void advance_ms();
        ms_now = ms_now + 32'd1;
        if (running && (ms_now - ms_last_step) >= {16'd0, step_period}) begin
            ms_last_step = ms_now;
            case (sel_pattern)
                PAT_SETUP:   looping_burst(regs.quick_interval, regs.setup_blinks);
                PAT_SUCCESS: one_shot_burst(regs.normal_interval, regs.success_blinks);
                PAT_ERROR:   one_shot_burst(regs.error_interval, regs.error_blinks);
                PAT_WIFI:    looping_burst(regs.slow_interval, regs.wifi_blinks);
                PAT_IO:      looping_burst(regs.normal_interval, IO_BURST);
                PAT_RESET:   one_shot_burst(regs.quick_interval, regs.error_blinks);
                PAT_ACTIVE: begin
                    pin    = 1'b0;
                    pwm_on = 1'b0;
                end
                PAT_IDLE:    fade_step();
                default: ;
            endcase
        end
    endfunction

    function automatic t_result predict_led(input logic act, input logic [3:0] pat);
        t_result r;
        if (act) begin
            toggles     = '0;
            phase       = 1'b0;
            running     = 1'b1;
            sel_pattern = pat;
            pin         = 1'b1;
            pwm_on      = 1'b0;
        end else begin
            advance_ms();
        end
        r.pin_level      = pin;
        r.pwm_level      = LEVEL_MAX - glow;
        r.pwm_select     = pwm_on;
        r.pattern_active = running;
        r.current_mode   = t_pattern'(sel_pattern);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            load_reset_state();
            words_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                store_reg(i_cfg_index, i_cfg_data);
            // pop before push so a word can never match its own prediction
            if (i_out_valid && i_out_ready) begin
                if (words_due.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatches++;
                end else begin
                    want = words_due.pop_front();
                    check_field("pin_level", 8'(want.pin_level), 8'(i_pin_level));
                    check_field("pwm_level", want.pwm_level, i_pwm_level);
                    check_field("pwm_select", 8'(want.pwm_select), 8'(i_pwm_select));
                    check_field("pattern_active", 8'(want.pattern_active),
                                8'(i_pattern_active));
                    check_field("current_mode", 8'(want.current_mode), 8'(i_current_mode));
                end
            end
            if (i_in_valid && i_in_ready)
                words_due.push_back(predict_led(i_in_action, i_in_pattern));
        end
        o_words_due <= words_due.size();
    end

endmodule

FILE: dv/tb_status_led_pattern_sequencer_top.sv
`timescale 1ns / 1ps

module tb_status_led_pattern_sequencer_top;
    import slps_pkg::*;

    // action codes of an input word
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // register indexes past the last one are ignored by the block
    localparam int unsigned CFG_SLOTS = 8;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT    = 5000;
    localparam int unsigned PHASE_WORDS    = 640;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_action;
    logic [3:0]             i_pattern;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_pin_level;
    logic [7:0]             o_pwm_level;
    logic                   o_pwm_select;
    logic                   o_pattern_active;
    logic [3:0]             o_current_mode;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int unsigned fail_count;
    int unsigned words_due;

    // traffic shaping, owned by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned words_sent    = 0;
    // bumped to ask the result side for one long hold-off
    int unsigned rx_hold_ticket = 0;

    status_led_pattern_sequencer_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_pattern        (i_pattern),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pin_level      (o_pin_level),
        .o_pwm_level      (o_pwm_level),
        .o_pwm_select     (o_pwm_select),
        .o_pattern_active (o_pattern_active),
        .o_current_mode   (o_current_mode),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // watches all three channels, predicts every result word and compares
    slps_result_check led_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_in_action      (i_action),
        .i_in_pattern     (i_pattern),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_pin_level      (o_pin_level),
        .i_pwm_level      (o_pwm_level),
        .i_pwm_select     (o_pwm_select),
        .i_pattern_active (o_pattern_active),
        .i_current_mode   (o_current_mode),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_words_due      (words_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin : result_sink
        int unsigned served;
        served  = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_ticket != served) begin
                served++;
                i_ready <= 1'b0;
                // count the hold-off here so the sender keeps pushing meanwhile
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one word and wait until it is taken; valid is only dropped
    // when a gap is inserted, so it never falls and rises in one step
    task automatic push_word(input logic act, input logic [3:0] pat);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_pattern <= pat;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        // two-stage pipe, let it settle before touching registers
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly short periods so bursts finish within a tick run; zero is the
    // step-on-every-tick case
    function automatic logic [15:0] pick_period();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'($urandom_range(13, 40));
            default: return 16'($urandom_range(2, 12));
        endcase
    endfunction

    // blink counts only use the low byte; the upper byte is random junk
    function automatic logic [15:0] pick_count();
        logic [7:0] junk;
        junk = 8'($urandom);
        case ($urandom_range(9))
            0:       return {junk, 8'd0};
            1:       return {junk, 8'd255};
            default: return {junk, 8'($urandom_range(1, 5))};
        endcase
    endfunction

    task automatic load_random_regs();
        write_reg(CFG_QUICK_INTERVAL, pick_period());
        write_reg(CFG_NORMAL_INTERVAL, pick_period());
        write_reg(CFG_SLOW_INTERVAL, pick_period());
        write_reg(CFG_ERROR_INTERVAL, pick_period());
        write_reg(CFG_SETUP_BLINKS, pick_count());
        write_reg(CFG_SUCCESS_BLINKS, pick_count());
        write_reg(CFG_ERROR_BLINKS, pick_count());
        write_reg(CFG_WIFI_BLINKS, pick_count());
        // out-of-range index, must leave every register alone
        write_reg(CFG_INDEX_W'($urandom_range(CFG_SLOTS, 15)), 16'($urandom));
    endtask

    // mostly a start followed by a run of ticks, the rest loose words;
    // idle gets extra weight so breathing has time to build up
    task automatic run_traffic(input int unsigned quota);
        int unsigned goal;
        int unsigned run_len;
        logic [3:0]  pick;
        goal = words_sent + quota;
        while (words_sent < goal) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 35)
                    pick = PAT_IDLE;
                else
                    pick = 4'($urandom_range(int'(PAT_SETUP), int'(PAT_ACTIVE)));
                push_word(ACT_START, pick);
                if ($urandom_range(5) == 0)
                    run_len = $urandom_range(40, 150);
                else
                    run_len = $urandom_range(1, 40);
                // the pattern field is don't-care on ticks, so fill it randomly
                repeat (run_len) push_word(ACT_TICK, 4'($urandom));
            end else begin
                push_word(1'($urandom), 4'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int unsigned guard;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_action    = ACT_TICK;
        i_pattern   = PAT_NONE;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_QUICK_INTERVAL;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, every start code including none and an
        // unknown one, a tick after each; tick while nothing runs first
        push_word(ACT_TICK, PAT_NONE);
        push_word(ACT_START, PAT_NONE);
        push_word(ACT_TICK, PAT_NONE);
        push_word(ACT_START, 4'hF);
        push_word(ACT_TICK, PAT_NONE);
        for (int p = int'(PAT_SETUP); p <= int'(PAT_IDLE); p++) begin
            push_word(ACT_START, 4'(p));
            push_word(ACT_TICK, PAT_NONE);
        end
        push_word(ACT_TICK, 4'hF);

        // phase 1: random registers, sender gaps 22%, receiver stalls 51%
        wait_quiet();
        load_random_regs();
        send_idle_pct = 22;
        recv_idle_pct = 51;
        run_traffic(PHASE_WORDS / 2);
        // sender pauses until everything is back
        wait_quiet();
        run_traffic(PHASE_WORDS / 2);

        // phase 2: register extremes, zero and max blink counts,
        // zero and one periods; gaps the other way round
        wait_quiet();
        write_reg(CFG_QUICK_INTERVAL, 16'd1);
        write_reg(CFG_NORMAL_INTERVAL, 16'd0);
        write_reg(CFG_SLOW_INTERVAL, 16'd40);
        write_reg(CFG_ERROR_INTERVAL, 16'd1);
        write_reg(CFG_SETUP_BLINKS, 16'hA5FF);
        write_reg(CFG_SUCCESS_BLINKS, 16'h5A00);
        write_reg(CFG_ERROR_BLINKS, 16'hFF01);
        write_reg(CFG_WIFI_BLINKS, 16'h00FF);
        write_reg(CFG_INDEX_W'(CFG_SLOTS), 16'hFFFF);
        send_idle_pct = 51;
        recv_idle_pct = 22;
        run_traffic(PHASE_WORDS);

        // phase 3: no idling at all, one long receiver hold-off up front so
        // the pipe fills and input ready drops
        wait_quiet();
        load_random_regs();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_ticket <= rx_hold_ticket + 1;
        run_traffic(PHASE_WORDS);

        // largest periods last: once a step loads them, nothing steps again
        wait_quiet();
        write_reg(CFG_SLOW_INTERVAL, 16'hFFFF);
        write_reg(CFG_ERROR_INTERVAL, 16'hFFFF);
        write_reg(CFG_QUICK_INTERVAL, 16'hFFFF);
        push_word(ACT_START, PAT_WIFI);
        repeat (30) push_word(ACT_TICK, PAT_NONE);

        // drain, bounded, then let the pipe settle
        i_valid <= 1'b0;
        guard = 0;
        while (words_due != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && words_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
